### sv/rrwt_pkg.sv
// Shared types and constants of the round-robin wait-time calculator.
`timescale 1ns / 1ps

package rrwt_pkg;

	// Field widths of the channels and of the internal timeline.
	localparam int BURST_W   = 16;
	localparam int QUANTUM_W = 16;
	localparam int TIME_W    = 20;
	localparam int TOTAL_W   = 24;
	localparam int PINDEX_W  = 4;

	// One state entry holds the remaining burst above the recorded wait.
	localparam int STATE_W = BURST_W + TIME_W;

	localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 16'd8;

	// Sequencer states: load the set, sweep it, then emit the results.
	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SWEEP_RD,
		ST_SWEEP_WR,
		ST_EMIT_RD,
		ST_EMIT_LD
	} state_t;

	// One result as it leaves the core.
	typedef struct packed {
		logic [PINDEX_W-1:0] process_index;
		logic [TIME_W-1:0]   wait_time;
		logic [TIME_W-1:0]   turnaround_time;
		logic [TOTAL_W-1:0]  total_wait;
		logic [TOTAL_W-1:0]  total_turnaround;
		logic                last_result;
	} result_t;

endpackage

### sv/rrwt_ifs.sv
// Handshake channels of the round-robin wait-time calculator.
`timescale 1ns / 1ps

// Process request channel: one burst time per request.
interface rrwt_proc_if;
	logic                          valid;
	logic                          ready;
	logic [rrwt_pkg::BURST_W-1:0]  burst_len;
	logic                          last_process;

	modport source (output valid, output burst_len, output last_process, input ready);
	modport sink (input valid, input burst_len, input last_process, output ready);
endinterface

// Result channel: one request per process of the set.
interface rrwt_result_if;
	logic                          valid;
	logic                          ready;
	logic [rrwt_pkg::PINDEX_W-1:0] process_index;
	logic [rrwt_pkg::TIME_W-1:0]   wait_time;
	logic [rrwt_pkg::TIME_W-1:0]   turnaround_time;
	logic [rrwt_pkg::TOTAL_W-1:0]  total_wait;
	logic [rrwt_pkg::TOTAL_W-1:0]  total_turnaround;
	logic                          last_result;

	modport source (output valid, output process_index, output wait_time,
		output turnaround_time, output total_wait, output total_turnaround,
		output last_result, input ready);
	modport sink (input valid, input process_index, input wait_time,
		input turnaround_time, input total_wait, input total_turnaround,
		input last_result, output ready);
endinterface

// Configuration write channel for the time quantum.
interface rrwt_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [rrwt_pkg::QUANTUM_W-1:0]  time_quantum;

	modport source (output valid, output time_quantum, input ready);
	modport sink (input valid, input time_quantum, output ready);
endinterface

### sv/rrwt_core.sv
// Sequencer, state memories and sweep datapath of the wait-time calculator.
`timescale 1ns / 1ps

module rrwt_core #(
	parameter int MAX_PROCS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [rrwt_pkg::BURST_W-1:0]     in_burst,
	input  logic                             in_last,
	input  logic [rrwt_pkg::QUANTUM_W-1:0]   quantum,
	output logic                             res_valid,
	input  logic                             res_ready,
	output rrwt_pkg::result_t                res
);

	localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int XW = (IW > rrwt_pkg::PINDEX_W) ? IW : rrwt_pkg::PINDEX_W;
	localparam logic [IW-1:0] LAST_SLOT = IW'(MAX_PROCS - 1);

	rrwt_pkg::state_t state_q, state_d;

	logic [IW-1:0]                  idx_q;
	logic [IW-1:0]                  last_idx_q;
	logic [rrwt_pkg::TIME_W-1:0]    time_q;
	logic                           pending_q;
	logic [rrwt_pkg::TOTAL_W-1:0]   tot_w_q;
	logic [rrwt_pkg::TOTAL_W-1:0]   tot_t_q;

	// State memories: burst per process, and remaining burst with wait.
	logic [rrwt_pkg::BURST_W-1:0]   burst_mem [MAX_PROCS];
	logic [rrwt_pkg::STATE_W-1:0]   state_mem [MAX_PROCS];
	logic [rrwt_pkg::BURST_W-1:0]   burst_rd_q;
	logic [rrwt_pkg::STATE_W-1:0]   state_rd_q;

	logic                           burst_we;
	logic                           state_we;
	logic                           load_sel;
	logic [rrwt_pkg::STATE_W-1:0]   state_wdata;

	logic [rrwt_pkg::QUANTUM_W-1:0] q_eff;
	logic [rrwt_pkg::BURST_W-1:0]   rem;
	logic [rrwt_pkg::TIME_W-1:0]    wt;
	logic [rrwt_pkg::BURST_W-1:0]   run;
	logic                           active;
	logic                           finishing;
	logic [rrwt_pkg::TIME_W-1:0]    time_nxt;
	logic [rrwt_pkg::BURST_W-1:0]   rem_nxt;
	logic [rrwt_pkg::TIME_W-1:0]    wait_nxt;
	logic                           in_fin;
	logic                           end_pass;
	logic                           sweep_more;
	logic                           res_fin;
	logic [rrwt_pkg::TIME_W-1:0]    turn;
	logic [rrwt_pkg::TOTAL_W-1:0]   tot_w_nxt;
	logic [rrwt_pkg::TOTAL_W-1:0]   tot_t_nxt;
	logic [XW-1:0]                  idx_wide;

	// A zero quantum behaves as a quantum of one.
	assign q_eff = (quantum == '0) ? rrwt_pkg::QUANTUM_W'(1) : quantum;

	// One turn of the process read from memory.
	always_comb begin
		rem       = state_rd_q[rrwt_pkg::STATE_W-1:rrwt_pkg::TIME_W];
		wt        = state_rd_q[rrwt_pkg::TIME_W-1:0];
		active    = (rem != '0);
		finishing = active && (rem <= q_eff);
		run       = (rem > q_eff) ? q_eff : rem;
		time_nxt  = time_q + rrwt_pkg::TIME_W'(run);
		rem_nxt   = rem - run;
		wait_nxt  = finishing ? (time_nxt - rrwt_pkg::TIME_W'(burst_rd_q)) : wt;
	end

	assign in_fin     = in_last || (idx_q == LAST_SLOT);
	assign end_pass   = (idx_q == last_idx_q);
	assign sweep_more = pending_q || active;
	assign res_fin    = (idx_q == last_idx_q);

	// Result fields and running totals.
	always_comb begin
		idx_wide  = XW'(idx_q);
		turn      = rrwt_pkg::TIME_W'(burst_rd_q) + wt;
		tot_w_nxt = tot_w_q + rrwt_pkg::TOTAL_W'(wt);
		tot_t_nxt = tot_t_q + rrwt_pkg::TOTAL_W'(turn);
		res.process_index    = idx_wide[rrwt_pkg::PINDEX_W-1:0];
		res.wait_time        = wt;
		res.turnaround_time  = turn;
		res.total_wait       = res_fin ? tot_w_nxt : '0;
		res.total_turnaround = res_fin ? tot_t_nxt : '0;
		res.last_result      = res_fin;
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			rrwt_pkg::ST_LOAD: begin
				if (in_valid && in_fin) state_d = rrwt_pkg::ST_SWEEP_RD;
			end
			rrwt_pkg::ST_SWEEP_RD: state_d = rrwt_pkg::ST_SWEEP_WR;
			rrwt_pkg::ST_SWEEP_WR: begin
				if (end_pass && !sweep_more) state_d = rrwt_pkg::ST_EMIT_RD;
				else state_d = rrwt_pkg::ST_SWEEP_RD;
			end
			rrwt_pkg::ST_EMIT_RD: state_d = rrwt_pkg::ST_EMIT_LD;
			rrwt_pkg::ST_EMIT_LD: begin
				if (res_ready) state_d = res_fin ? rrwt_pkg::ST_LOAD : rrwt_pkg::ST_EMIT_RD;
			end
			default: state_d = rrwt_pkg::ST_LOAD;
		endcase
	end

	// Output decode of the sequencer.
	always_comb begin
		in_ready  = 1'b0;
		res_valid = 1'b0;
		burst_we  = 1'b0;
		state_we  = 1'b0;
		load_sel  = 1'b0;
		case (state_q)
			rrwt_pkg::ST_LOAD: begin
				in_ready = 1'b1;
				burst_we = in_valid;
				state_we = in_valid;
				load_sel = 1'b1;
			end
			rrwt_pkg::ST_SWEEP_WR: state_we = active;
			rrwt_pkg::ST_EMIT_LD: res_valid = 1'b1;
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign state_wdata = load_sel ? {in_burst, rrwt_pkg::TIME_W'(0)} : {rem_nxt, wait_nxt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= rrwt_pkg::ST_LOAD;
		else state_q <= state_d;
	end

	// Burst memory: written while loading, read at the current index.
	always_ff @(posedge clk) begin
		if (burst_we) burst_mem[idx_q] <= in_burst;
		burst_rd_q <= burst_mem[idx_q];
	end

	// State memory: written while loading and on every active turn.
	always_ff @(posedge clk) begin
		if (state_we) state_mem[idx_q] <= state_wdata;
		state_rd_q <= state_mem[idx_q];
	end

	// Index, timeline, pass flag and totals.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			last_idx_q <= '0;
			time_q     <= '0;
			pending_q  <= 1'b0;
			tot_w_q    <= '0;
			tot_t_q    <= '0;
		end else begin
			case (state_q)
				rrwt_pkg::ST_LOAD: begin
					if (in_valid) begin
						if (in_fin) begin
							idx_q      <= '0;
							last_idx_q <= idx_q;
							time_q     <= '0;
							pending_q  <= 1'b0;
						end else begin
							idx_q <= idx_q + IW'(1);
						end
					end
				end
				rrwt_pkg::ST_SWEEP_WR: begin
					time_q <= time_nxt;
					if (end_pass) begin
						idx_q     <= '0;
						pending_q <= 1'b0;
						tot_w_q   <= '0;
						tot_t_q   <= '0;
					end else begin
						idx_q     <= idx_q + IW'(1);
						pending_q <= pending_q || active;
					end
				end
				rrwt_pkg::ST_EMIT_LD: begin
					if (res_ready) begin
						tot_w_q <= tot_w_nxt;
						tot_t_q <= tot_t_nxt;
						idx_q   <= res_fin ? '0 : idx_q + IW'(1);
					end
				end
				default: begin
					idx_q <= idx_q;
				end
			endcase
		end
	end

endmodule

### sv/round_robin_wait_times.sv
// Round-robin wait-time calculator: configuration, output register and core.
//
// Usage: the procs channel takes one burst time per request, in load order.
// A request with last_process set, or the MAX_PROCS-th request, closes the
// set. The block then replays round-robin service with the quantum held in
// the configuration register (written over cfg, reset value 8, zero acts as
// one) and sends one request per process on results, in load order; the
// last carries the totals. Then it takes the next set.
// While loading, procs.ready stays high, so requests are taken back to back.
// The sweep reads and writes back one state memory entry per process
// visit, in a read state and a write state, and ends after a full pass
// that finds every process done. Each result is read from memory in a
// read state, then offered in a load state until the core may pass it on.
// The output register lets the next set load while the final result waits.
// A stalled receiver holds the result and the emit sequence in place.
// Reset clears the sequencer and the register; the memories need no clear.

`timescale 1ns / 1ps

module round_robin_wait_times #(
	parameter int MAX_PROCS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	rrwt_proc_if.sink     procs,
	rrwt_result_if.source results,
	rrwt_cfg_if.sink      cfg
);

	logic [rrwt_pkg::QUANTUM_W-1:0] quantum_q;
	logic                           res_valid;
	logic                           res_ready;
	rrwt_pkg::result_t              res;
	rrwt_pkg::result_t              out_q;
	logic                           out_valid_q;

	// Quantum register; writes are always taken.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) quantum_q <= rrwt_pkg::QUANTUM_RESET;
		else if (cfg.valid) quantum_q <= cfg.time_quantum;
	end

	rrwt_core #(
		.MAX_PROCS(MAX_PROCS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (procs.valid),
		.in_ready  (procs.ready),
		.in_burst  (procs.burst_len),
		.in_last   (procs.last_process),
		.quantum   (quantum_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Output register: loads when empty or when its request is taken.
	assign res_ready = !out_valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (res_valid && res_ready) out_valid_q <= 1'b1;
		else if (results.ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) out_q <= res;
	end

	assign results.valid            = out_valid_q;
	assign results.process_index    = out_q.process_index;
	assign results.wait_time        = out_q.wait_time;
	assign results.turnaround_time  = out_q.turnaround_time;
	assign results.total_wait       = out_q.total_wait;
	assign results.total_turnaround = out_q.total_turnaround;
	assign results.last_result      = out_q.last_result;

endmodule

### dv/rrwt_wait_checker.sv
// Checker that predicts and compares the round-robin wait-time results.
`timescale 1ns / 1ps

module rrwt_wait_checker #(
	parameter int PROC_SLOTS = 16
) (
	input  logic   clk,
	input  logic   arst_n,
	rrwt_proc_if   procs,
	rrwt_result_if results,
	rrwt_cfg_if    cfg,
	output int     fail_count,
	output int     pending_results,
	output int     sets_closed,
	output int     results_checked
);

	// Quantum as the block should hold it, and the bursts of the set being loaded.
	logic [rrwt_pkg::QUANTUM_W-1:0] quantum_now = rrwt_pkg::QUANTUM_RESET;
	logic [rrwt_pkg::BURST_W-1:0]   open_set[$];
	rrwt_pkg::result_t              expected_results[$];

	initial begin
		fail_count = 0;
		pending_results = 0;
		sets_closed = 0;
		results_checked = 0;
	end

	// Print one line per mismatch, up to a cap, and count every one.
	task automatic flag_mismatch(input string what);
		if (fail_count < 30) begin
			$display("[%0t] MISMATCH: %s", $realtime, what);
		end
		fail_count++;
	endtask

	// Replay round-robin service over the closed set and queue one result per process.
	function automatic void schedule_round_robin();
		logic [rrwt_pkg::BURST_W-1:0]   left[PROC_SLOTS];
		logic [rrwt_pkg::TIME_W-1:0]    waits[PROC_SLOTS];
		logic [rrwt_pkg::TIME_W-1:0]    clock_now;
		logic [rrwt_pkg::QUANTUM_W-1:0] slice;
		logic [rrwt_pkg::TOTAL_W-1:0]   sum_wait;
		logic [rrwt_pkg::TOTAL_W-1:0]   sum_turn;
		bit                             busy;
		int                             count;
		rrwt_pkg::result_t              r;

		count = open_set.size();
		// A zero quantum behaves as a quantum of one.
		slice = (quantum_now == '0) ? rrwt_pkg::QUANTUM_W'(1) : quantum_now;
		clock_now = '0;
		for (int k = 0; k < count; k++) begin
			left[k] = open_set[k];
			waits[k] = '0;
		end
		busy = 1'b1;
		while (busy) begin
			busy = 1'b0;
			for (int k = 0; k < count; k++) begin
				if (left[k] != '0) begin
					busy = 1'b1;
					if (left[k] > slice) begin
						clock_now = clock_now + rrwt_pkg::TIME_W'(slice);
						left[k] = left[k] - slice;
					end else begin
						clock_now = clock_now + rrwt_pkg::TIME_W'(left[k]);
						waits[k] = clock_now - rrwt_pkg::TIME_W'(open_set[k]);
						left[k] = '0;
					end
				end
			end
		end

		// Totals ride only on the final result of the set.
		sum_wait = '0;
		sum_turn = '0;
		for (int k = 0; k < count; k++) begin
			r.process_index = rrwt_pkg::PINDEX_W'(k);
			r.wait_time = waits[k];
			r.turnaround_time = rrwt_pkg::TIME_W'(open_set[k]) + waits[k];
			sum_wait = sum_wait + rrwt_pkg::TOTAL_W'(r.wait_time);
			sum_turn = sum_turn + rrwt_pkg::TOTAL_W'(r.turnaround_time);
			r.last_result = (k == count - 1);
			r.total_wait = r.last_result ? sum_wait : '0;
			r.total_turnaround = r.last_result ? sum_turn : '0;
			expected_results.push_back(r);
		end
		open_set.delete();
	endfunction

	// Compare one accepted result with the oldest expectation, field by field.
	task automatic check_result();
		rrwt_pkg::result_t got;
		rrwt_pkg::result_t want;

		got.process_index = results.process_index;
		got.wait_time = results.wait_time;
		got.turnaround_time = results.turnaround_time;
		got.total_wait = results.total_wait;
		got.total_turnaround = results.total_turnaround;
		got.last_result = results.last_result;
		results_checked++;
		if (expected_results.size() == 0) begin
			flag_mismatch($sformatf("result for process %0d arrived with none expected",
				got.process_index));
			return;
		end
		want = expected_results.pop_front();
		if (got.process_index !== want.process_index)
			flag_mismatch($sformatf("process_index got %0d expected %0d",
				got.process_index, want.process_index));
		if (got.wait_time !== want.wait_time)
			flag_mismatch($sformatf("process %0d wait_time got %0d expected %0d",
				want.process_index, got.wait_time, want.wait_time));
		if (got.turnaround_time !== want.turnaround_time)
			flag_mismatch($sformatf("process %0d turnaround_time got %0d expected %0d",
				want.process_index, got.turnaround_time, want.turnaround_time));
		if (got.total_wait !== want.total_wait)
			flag_mismatch($sformatf("process %0d total_wait got %0d expected %0d",
				want.process_index, got.total_wait, want.total_wait));
		if (got.total_turnaround !== want.total_turnaround)
			flag_mismatch($sformatf("process %0d total_turnaround got %0d expected %0d",
				want.process_index, got.total_turnaround, want.total_turnaround));
		if (got.last_result !== want.last_result)
			flag_mismatch($sformatf("process %0d last_result got %0d expected %0d",
				want.process_index, got.last_result, want.last_result));
	endtask

	// Watch all three channels at each rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg.valid && cfg.ready) begin
				quantum_now = cfg.time_quantum;
			end
			if (procs.valid && procs.ready) begin
				open_set.push_back(procs.burst_len);
				// The set closes on a marked request or when every slot is full.
				if (procs.last_process || open_set.size() == PROC_SLOTS) begin
					schedule_round_robin();
					sets_closed++;
				end
			end
			if (results.valid && results.ready) begin
				check_result();
			end
			pending_results = expected_results.size();
		end
	end

endmodule

### dv/round_robin_wait_times_tb.sv
// Top of the round-robin wait-time testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module round_robin_wait_times_tb;

	localparam int PROC_SLOTS       = 16;
	localparam int SETTLE_CYCLES    = 20;
	localparam int DRAIN_CYCLES     = 300;
	localparam int LONG_HOLD_CYCLES = 2000;
	localparam int PHASE_ITEMS      = 16;
	localparam int BURST_SPAN       = 24;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// Shared stimulus modes: no idling at all, and a requested long output stall.
	bit steady_phase = 1'b0;
	bit long_hold_pending = 1'b0;

	int fail_count;
	int pending_results;
	int sets_closed;
	int results_checked;

	rrwt_proc_if   procs_ch();
	rrwt_result_if results_ch();
	rrwt_cfg_if    cfg_ch();

	round_robin_wait_times #(
		.MAX_PROCS(PROC_SLOTS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.procs(procs_ch),
		.results(results_ch),
		.cfg(cfg_ch)
	);

	rrwt_wait_checker #(
		.PROC_SLOTS(PROC_SLOTS)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.procs(procs_ch),
		.results(results_ch),
		.cfg(cfg_ch),
		.fail_count(fail_count),
		.pending_results(pending_results),
		.sets_closed(sets_closed),
		.results_checked(results_checked)
	);

	always #5 clk = ~clk;

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int pick_gap();
		int roll;

		roll = $urandom_range(0, 99);
		if (steady_phase || roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Offer one process request; entered and left at a falling edge.
	task automatic offer_process(input logic [rrwt_pkg::BURST_W-1:0] burst, input logic last);
		int gap;

		gap = pick_gap();
		if (gap > 0) begin
			procs_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		procs_ch.valid <= 1'b1;
		procs_ch.burst_len <= burst;
		procs_ch.last_process <= last;
		do @(posedge clk); while (!procs_ch.ready);
		@(negedge clk);
	endtask

	// Write the quantum register and wait for the request to be taken.
	task automatic write_quantum(input logic [rrwt_pkg::QUANTUM_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.time_quantum <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Stop offering and let every expected result come out before touching the register.
	task automatic settle_idle();
		procs_ch.valid <= 1'b0;
		while (pending_results != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// One set of random size and bursts, scaled so the sweep stays short.
	task automatic send_random_set(input int slice, output int count);
		int  roll;
		int  bound;
		int  burst;
		bit  mark_full;
		logic last;

		roll = $urandom_range(0, 99);
		if (roll < 55)
			count = $urandom_range(1, 6);
		else if (roll < 80)
			count = $urandom_range(7, PROC_SLOTS - 1);
		else
			count = PROC_SLOTS;
		mark_full = $urandom_range(0, 1);
		bound = ((slice == 0) ? 1 : slice) * BURST_SPAN;
		if (bound > 65535)
			bound = 65535;
		for (int k = 0; k < count; k++) begin
			roll = $urandom_range(0, 99);
			if (roll < 10)
				burst = 0;
			else if (roll < 20)
				burst = bound;
			else
				burst = $urandom_range(0, bound);
			// A full set closes by itself; its final request is marked only at random.
			last = (k == count - 1) && (count < PROC_SLOTS || mark_full);
			offer_process(rrwt_pkg::BURST_W'(burst), last);
		end
	endtask

	// Result receiver: random stalls, plus one long hold while the sender keeps going.
	initial begin : receiver
		int run;

		results_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (long_hold_pending) begin
				long_hold_pending = 1'b0;
				results_ch.ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(negedge clk);
			end else begin
				results_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(negedge clk);
				run = pick_gap();
				if (run > 0) begin
					results_ch.ready <= 1'b0;
					repeat (run) @(negedge clk);
				end
			end
		end
	end

	// Stimulus: directed sets, then random phases under several quanta.
	initial begin : stimulus
		int count;
		int phase_items;
		int slice;

		procs_ch.valid = 1'b0;
		procs_ch.burst_len = '0;
		procs_ch.last_process = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.time_quantum = '0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset quantum: a lone zero burst, a mixed set, a lone maximum burst.
		offer_process(16'd0, 1'b1);
		offer_process(16'd5, 1'b0);
		offer_process(16'd0, 1'b0);
		offer_process(16'd20, 1'b0);
		offer_process(16'd8, 1'b0);
		offer_process(16'd9, 1'b1);
		offer_process(16'hFFFF, 1'b1);

		// Largest quantum with a full set of maximum bursts that closes by itself.
		settle_idle();
		write_quantum(16'hFFFF);
		for (int k = 0; k < PROC_SLOTS; k++) begin
			offer_process(16'hFFFF, 1'b0);
		end

		// A zero quantum acts as a quantum of one.
		settle_idle();
		write_quantum(16'd0);
		offer_process(16'd3, 1'b0);
		offer_process(16'd1, 1'b0);
		offer_process(16'd2, 1'b1);

		// Random phases, each under its own quantum.
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: slice = 1;
				1: slice = 65535;
				2: slice = $urandom_range(2, 40);
				3: slice = $urandom_range(41, 4000);
				default: slice = $urandom_range(1, 65535);
			endcase
			settle_idle();
			write_quantum(rrwt_pkg::QUANTUM_W'(slice));
			steady_phase = (phase == 2);
			if (phase == 1)
				long_hold_pending = 1'b1;
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				send_random_set(slice, count);
				phase_items += count;
			end
		end

		// Drain, then give stray results a chance to show up.
		settle_idle();
		steady_phase = 1'b0;
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Run covered %0d process sets and %0d results under quanta 8, 65535, 0, 1",
			sets_closed, results_checked);
		$display("and random values, with zero bursts, full sets and a %0d-cycle output stall.",
			LONG_HOLD_CYCLES);
		if (fail_count == 0 && pending_results == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// Hard limit well beyond the slowest correct run.
	initial begin : watchdog
		#5000000;
		$display("Timeout with %0d results still expected", pending_results);
		$display("Test completed with failures");
		$finish;
	end

endmodule

### files.f
sv/rrwt_pkg.sv
sv/rrwt_ifs.sv
sv/rrwt_core.sv
sv/round_robin_wait_times.sv
dv/rrwt_wait_checker.sv
dv/round_robin_wait_times_tb.sv
